/* hw/rtl/wmf_pkg.sv */
// Package with the types and constants of the widescreen metatile fetch unit.
package wmf_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_WR_MAP   = 2'd1,
    CMD_WR_TILE  = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_UNAVAIL  = 2'd0,
    ST_REPLACED = 2'd1,
    ST_KEEP     = 2'd2,
    ST_WRITTEN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_CAMERA_X    = 3'd0,
    CFG_CAMERA_Y    = 3'd1,
    CFG_ROOM_WIDTH  = 3'd2,
    CFG_TRANSITION  = 3'd3,
    CFG_ROOM_LOADED = 3'd4
  } cfg_index_t;

  localparam logic [1:0] LAYER_BG1 = 2'd1;
  localparam logic [1:0] LAYER_BG2 = 2'd2;

  localparam int PB_MARGIN = 22;
  localparam int PB_VIEW   = 240;

  localparam int FLIP_X_BIT = 14;
  localparam int FLIP_Y_BIT = 15;
  localparam int ID_W       = 14;

  localparam int ADDR_W = 20;

  typedef struct packed {
    logic full;
    logic left;
    logic right;
  } pb_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  layer;
    logic [17:0] wx;
    logic [17:0] wy;
    logic [13:0] waddr;
    logic [15:0] wdata;
    pb_t         pb;
    logic        active;
  } s1_t;

  typedef struct packed {
    status_t           stat;
    logic              look;
    logic              bm_we;
    logic              mt_we;
    logic [ADDR_W-1:0] addr;
    logic [13:0]       waddr;
    logic [15:0]       wdata;
    logic [1:0]        subx;
    logic [1:0]        suby;
    pb_t               pb;
  } map_stage_t;

  typedef struct packed {
    status_t           stat;
    logic              look;
    logic              mt_we;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
    logic [1:0]        flip;
    pb_t               pb;
  } tile_stage_t;

endpackage

/* hw/rtl/widescreen_metatile_fetch_unit.sv */
// Top level of the widescreen metatile fetch unit: a six-stage lookup and write pipeline.
//
// The unit takes one command in every clock cycle and answers each with exactly one result,
// marked by done as it leaves the output register; results leave in command order and the
// receiver cannot stall them. busy is high only while rst is held. The block map is read
// and written in stage three and the metatile table in stage five, so a write always reaches
// a store before any later lookup reads it and the stores need no clearing after reset.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and should only
// change while no command is in flight.
module widescreen_metatile_fetch_unit
  import wmf_pkg::*;
#(
  parameter int BLOCK_MAP_ENTRIES = 4096,
  parameter int METATILE_ENTRIES  = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [1:0]        layer,
  input  logic signed [9:0] screen_x,
  input  logic signed [8:0] sample_y,
  input  logic [13:0]       write_address,
  input  logic [15:0]       write_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              done,
  output logic [1:0]        status,
  output logic [15:0]       tile_entry,
  output logic              pillarbox_full,
  output logic              pillarbox_left,
  output logic              pillarbox_right
);

  localparam int BM_AW = $clog2(BLOCK_MAP_ENTRIES);
  localparam int MT_AW = $clog2(METATILE_ENTRIES);
  localparam logic [ADDR_W:0] BM_LIMIT = (ADDR_W + 1)'(BLOCK_MAP_ENTRIES);
  localparam logic [ADDR_W:0] MT_LIMIT = (ADDR_W + 1)'(METATILE_ENTRIES);

  logic [15:0] camera_x;
  logic [15:0] camera_y;
  logic [7:0]  room_width_screens;
  logic        transition_active;
  logic        room_loaded;

  logic        accept;
  logic        v1, v2, v3, v4, v5;
  s1_t         s1, s1_next;
  map_stage_t  s2, s2_next, s3;
  tile_stage_t s4, s4_next, s5;
  logic [15:0] bm_q;
  logic [15:0] mt_q;

  logic [15:0] bm_mem [BLOCK_MAP_ENTRIES];
  logic [15:0] mt_mem [METATILE_ENTRIES];

  logic [15:0]       by_prod;
  logic [ADDR_W-1:0] bidx;
  logic              in_world;
  logic [ID_W-1:0]   block_id;
  logic [1:0]        subx_f;
  logic [1:0]        suby_f;
  logic [17:0]       midx;
  logic [16:0]       room_px;
  logic              wall_left;
  logic              wall_right;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x           <= '0;
      camera_y           <= '0;
      room_width_screens <= '0;
      transition_active  <= 1'b0;
      room_loaded        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAMERA_X:    camera_x           <= cfg_data;
        CFG_CAMERA_Y:    camera_y           <= cfg_data;
        CFG_ROOM_WIDTH:  room_width_screens <= cfg_data[7:0];
        CFG_TRANSITION:  transition_active  <= cfg_data[0];
        CFG_ROOM_LOADED: room_loaded        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage one: world position and pillarbox decisions.
  assign room_px    = {1'b0, room_width_screens, 8'h00};
  assign wall_left  = camera_x < 16'(PB_MARGIN);
  assign wall_right = ({1'b0, camera_x} + 17'(PB_MARGIN + PB_VIEW)) > room_px;

  always_comb begin
    s1_next.cmd    = cmd_t'(command);
    s1_next.layer  = layer;
    s1_next.wx     = {2'b00, camera_x} + {{8{screen_x[9]}}, screen_x};
    s1_next.wy     = {2'b00, camera_y} + {{9{sample_y[8]}}, sample_y};
    s1_next.waddr  = write_address;
    s1_next.wdata  = write_data;
    s1_next.pb     = '0;
    s1_next.active = 1'b0;
    if (!room_loaded || room_width_screens <= 8'd1 || transition_active) begin
      s1_next.pb.full = 1'b1;
    end else begin
      s1_next.active = 1'b1;
      if (wall_left && wall_right) begin
        s1_next.pb.full = 1'b1;
      end else begin
        s1_next.pb.left  = wall_left;
        s1_next.pb.right = wall_right;
      end
    end
  end

  // Stage two: bounds, block index and command decode.
  assign by_prod  = 16'(s1.wy[12:5]) * 16'(room_width_screens);
  assign bidx     = ADDR_W'({by_prod, 3'b000}) + ADDR_W'(s1.wx[15:5]);
  assign in_world = !s1.wx[17] && !s1.wy[17] && (s1.wx[16:0] < room_px);

  always_comb begin
    s2_next.stat  = ST_UNAVAIL;
    s2_next.look  = 1'b0;
    s2_next.bm_we = 1'b0;
    s2_next.mt_we = 1'b0;
    s2_next.addr  = ADDR_W'(s1.waddr);
    s2_next.waddr = s1.waddr;
    s2_next.wdata = s1.wdata;
    s2_next.subx  = s1.wx[4:3];
    s2_next.suby  = s1.wy[4:3];
    s2_next.pb    = s1.pb;
    unique case (s1.cmd)
      CMD_WR_MAP: begin
        if ((ADDR_W + 1)'(s1.waddr) < BM_LIMIT) begin
          s2_next.bm_we = 1'b1;
          s2_next.stat  = ST_WRITTEN;
        end
      end
      CMD_WR_TILE: begin
        if ((ADDR_W + 1)'(s1.waddr) < MT_LIMIT) begin
          s2_next.mt_we = 1'b1;
          s2_next.stat  = ST_WRITTEN;
        end
      end
      CMD_LOOKUP: begin
        if (s1.layer != LAYER_BG1 && s1.layer != LAYER_BG2) begin
          s2_next.stat = ST_KEEP;
        end else if (s1.active && in_world && {1'b0, bidx} < BM_LIMIT) begin
          s2_next.look = 1'b1;
          s2_next.addr = bidx;
        end
      end
      default: ;
    endcase
  end

  // Stage four: flips applied and metatile index formed.
  assign block_id = bm_q[ID_W-1:0];
  assign subx_f   = s3.subx ^ {2{bm_q[FLIP_X_BIT]}};
  assign suby_f   = s3.suby ^ {2{bm_q[FLIP_Y_BIT]}};
  assign midx     = {block_id - ID_W'(1), suby_f, subx_f};

  always_comb begin
    s4_next.stat  = s3.stat;
    s4_next.look  = s3.look && (block_id != '0) && ((ADDR_W + 1)'(midx) < MT_LIMIT);
    s4_next.mt_we = s3.mt_we;
    s4_next.addr  = s3.look ? ADDR_W'(midx) : ADDR_W'(s3.waddr);
    s4_next.wdata = s3.wdata;
    s4_next.flip  = bm_q[FLIP_Y_BIT:FLIP_X_BIT];
    s4_next.pb    = s3.pb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
    s2 <= s2_next;
    s3 <= s2;
    s4 <= s4_next;
    s5 <= s4;
  end

  always_ff @(posedge clk) begin
    if (v2 && s2.bm_we) begin
      bm_mem[s2.addr[BM_AW-1:0]] <= s2.wdata;
    end
    if (v2 && s2.look) begin
      bm_q <= bm_mem[s2.addr[BM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && s4.mt_we) begin
      mt_mem[s4.addr[MT_AW-1:0]] <= s4.wdata;
    end
    if (v4 && s4.look) begin
      mt_q <= mt_mem[s4.addr[MT_AW-1:0]];
    end
  end

  // Stage six: merge of the palette flip bits and the output register.
  always_ff @(posedge clk) begin
    status          <= s5.look ? ST_REPLACED : s5.stat;
    tile_entry      <= s5.look ? (mt_q ^ {4'b0000, s5.flip, 10'b0}) : 16'h0000;
    pillarbox_full  <= s5.pb.full;
    pillarbox_left  <= s5.pb.left;
    pillarbox_right <= s5.pb.right;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("Accepted command produced no result after six cycles.");

  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_REPLACED) |-> tile_entry == 16'h0000)
    else $error("Tile entry is not zero on a result that is not a replacement.");

  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    (done && pillarbox_full) |-> (!pillarbox_left && !pillarbox_right))
    else $error("Full pillarbox reported together with a side margin.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(v5)) |-> 1'b0)
    else $error("Result strobe raised without a command in the last stage.");
`endif

endmodule

/* verif/wmf_checker.sv */
`timescale 1ns / 1ps
// Checker for the widescreen metatile fetch unit: mirrors state, predicts and compares results.
module wmf_checker
  import wmf_pkg::*;
#(
  parameter int BLOCK_MAP_ENTRIES = 4096,
  parameter int METATILE_ENTRIES  = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        command,
  input  logic [1:0]        layer,
  input  logic signed [9:0] screen_x,
  input  logic signed [8:0] sample_y,
  input  logic [13:0]       write_address,
  input  logic [15:0]       write_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [15:0]       tile_entry,
  input  logic              pillarbox_full,
  input  logic              pillarbox_left,
  input  logic              pillarbox_right,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                replaced
);

  typedef struct packed {
    status_t     stat;
    logic [15:0] entry;
    pb_t         pb;
  } fetch_result_t;

  logic [15:0] block_map [BLOCK_MAP_ENTRIES];
  logic [15:0] metatile [METATILE_ENTRIES];
  logic [15:0] cam_x, cam_y;
  logic [7:0]  room_w;
  logic        in_transition, loaded;

  fetch_result_t expected_q[$];
  int n_fail = 0;
  int n_checked = 0;
  int n_replaced = 0;

  function automatic fetch_result_t predict_fetch(cmd_t cmd, logic [1:0] lyr,
                                                  logic signed [9:0] sx, logic signed [8:0] sy,
                                                  logic [13:0] addr);
    fetch_result_t r;
    logic        active;
    int          room_px, wx, wy, tx, ty, bidx, midx;
    logic [15:0] blk;
    logic [1:0]  subx, suby;
    r.stat = ST_UNAVAIL;
    r.entry = '0;
    room_px = int'(room_w) * 256;
    active = loaded && room_w > 1 && !in_transition;
    if (!active) begin
      r.pb = '{full: 1'b1, left: 1'b0, right: 1'b0};
    end else begin
      r.pb.left = int'(cam_x) < PB_MARGIN;
      r.pb.right = int'(cam_x) + PB_MARGIN > room_px - PB_VIEW;
      r.pb.full = r.pb.left && r.pb.right;
      if (r.pb.full) begin
        r.pb.left = 1'b0;
        r.pb.right = 1'b0;
      end
    end
    case (cmd)
      CMD_WR_MAP: if (addr < BLOCK_MAP_ENTRIES) r.stat = ST_WRITTEN;
      CMD_WR_TILE: if (addr < METATILE_ENTRIES) r.stat = ST_WRITTEN;
      CMD_LOOKUP: begin
        if (lyr != LAYER_BG1 && lyr != LAYER_BG2) begin
          r.stat = ST_KEEP;
        end else if (active) begin
          wx = int'(cam_x) + int'(sx);
          wy = int'(cam_y) + int'(sy);
          if (wx >= 0 && wy >= 0 && wx < room_px) begin
            tx = wx >> 3;
            ty = wy >> 3;
            // Only the low eight bits of the block row take part in the index.
            bidx = (tx >> 2) + ((ty >> 2) & 255) * int'(room_w) * 8;
            if (bidx < BLOCK_MAP_ENTRIES) begin
              blk = block_map[bidx];
              if (blk[ID_W-1:0] != 0) begin
                subx = tx[1:0] ^ {2{blk[FLIP_X_BIT]}};
                suby = ty[1:0] ^ {2{blk[FLIP_Y_BIT]}};
                midx = ((int'(blk[ID_W-1:0]) - 1) << 4) + int'({suby, subx});
                if (midx < METATILE_ENTRIES) begin
                  r.entry = metatile[midx] ^ {4'b0, blk[FLIP_Y_BIT], blk[FLIP_X_BIT], 10'b0};
                  r.stat = ST_REPLACED;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    fetch_result_t want, got;
    if (rst) begin
      cam_x = '0;
      cam_y = '0;
      room_w = '0;
      in_transition = 1'b0;
      loaded = 1'b0;
      expected_q.delete();
    end else begin
      if (done) begin
        got.stat = status_t'(status);
        got.entry = tile_entry;
        got.pb = '{pillarbox_full, pillarbox_left, pillarbox_right};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d entry %h",
                   $time, got.stat, got.entry);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.stat, got.stat);
          check_field("tile_entry", want.entry, got.entry);
          check_field("pillarbox_full", want.pb.full, got.pb.full);
          check_field("pillarbox_left", want.pb.left, got.pb.left);
          check_field("pillarbox_right", want.pb.right, got.pb.right);
          n_checked++;
          if (want.stat == ST_REPLACED) n_replaced++;
        end
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_CAMERA_X:    cam_x = cfg_data;
          CFG_CAMERA_Y:    cam_y = cfg_data;
          CFG_ROOM_WIDTH:  room_w = cfg_data[7:0];
          CFG_TRANSITION:  in_transition = cfg_data[0];
          CFG_ROOM_LOADED: loaded = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_q.push_back(predict_fetch(cmd_t'(command), layer, screen_x, sample_y,
                                           write_address));
        if (command == CMD_WR_MAP && write_address < BLOCK_MAP_ENTRIES)
          block_map[write_address] = write_data;
        if (command == CMD_WR_TILE && write_address < METATILE_ENTRIES)
          metatile[write_address] = write_data;
      end
    end
    pending <= expected_q.size();
    fail_count <= n_fail;
    checked <= n_checked;
    replaced <= n_replaced;
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the widescreen metatile fetch unit: stimulus, register settings and verdict.
module tb;
  import wmf_pkg::*;

  localparam int BM_DEPTH = 4096;
  localparam int MT_DEPTH = 8192;
  localparam logic [1:0] LAYER_BG0 = 2'd0;
  localparam logic [1:0] LAYER_BG3 = 2'd3;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        command;
  logic [1:0]        layer;
  logic signed [9:0] screen_x;
  logic signed [8:0] sample_y;
  logic [13:0]       write_address;
  logic [15:0]       write_data;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [15:0]       cfg_data;
  logic              done;
  logic [1:0]        status;
  logic [15:0]       tile_entry;
  logic              pillarbox_full;
  logic              pillarbox_left;
  logic              pillarbox_right;
  int                fail_count, pending, checked, replaced;

  widescreen_metatile_fetch_unit #(
    .BLOCK_MAP_ENTRIES(BM_DEPTH),
    .METATILE_ENTRIES (MT_DEPTH)
  ) u_dut (.*);

  wmf_checker #(
    .BLOCK_MAP_ENTRIES(BM_DEPTH),
    .METATILE_ENTRIES (MT_DEPTH)
  ) u_checker (.*);

  // Shadow of the settings and of which store entries hold data, so that lookups never
  // read an entry before it has been written.
  logic [15:0] cam_x, cam_y;
  logic [7:0]  room_w;
  logic        in_transition, loaded;
  logic [15:0] map_word [BM_DEPTH];
  bit          map_set [BM_DEPTH];
  bit          tile_set [MT_DEPTH];
  int          idle_pct = 0;
  int          n_items = 0;
  int          n_phases = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic transfer(cmd_t cmd, logic [1:0] lyr, logic [9:0] sx, logic [8:0] sy,
                          logic [13:0] addr, logic [15:0] data);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    layer <= lyr;
    screen_x <= sx;
    sample_y <= sy;
    write_address <= addr;
    write_data <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    if (cmd == CMD_WR_MAP && addr < BM_DEPTH) begin
      map_word[addr] = data;
      map_set[addr] = 1'b1;
    end
    if (cmd == CMD_WR_TILE && addr < MT_DEPTH) tile_set[addr] = 1'b1;
  endtask

  function automatic logic [15:0] block_word();
    int          pick;
    logic [13:0] id;
    pick = $urandom_range(99);
    if (pick < 8) id = '0;
    else if (pick < 16) id = 14'($urandom_range(513, 16383));
    else id = 14'($urandom_range(1, 512));
    return {2'($urandom), id};
  endfunction

  // Works out which block map slot a lookup reads, if any, and its unflipped subtile.
  function automatic bit map_slot(logic [1:0] lyr, logic [9:0] sx, logic [8:0] sy,
                                  output int bidx, output int sub);
    int wx, wy, tx, ty;
    bidx = 0;
    sub = 0;
    if ((lyr == LAYER_BG1 || lyr == LAYER_BG2) && loaded && room_w > 1 && !in_transition) begin
      wx = int'(cam_x) + int'($signed(sx));
      wy = int'(cam_y) + int'($signed(sy));
      if (wx >= 0 && wy >= 0 && wx < int'(room_w) * 256) begin
        tx = wx >> 3;
        ty = wy >> 3;
        bidx = (tx >> 2) + ((ty >> 2) & 255) * int'(room_w) * 8;
        sub = int'({ty[1:0], tx[1:0]});
        return bidx < BM_DEPTH;
      end
    end
    return 1'b0;
  endfunction

  task automatic lookup(logic [1:0] lyr, logic [9:0] sx, logic [8:0] sy);
    int          bidx, sub, midx;
    logic [15:0] blk;
    if (map_slot(lyr, sx, sy, bidx, sub)) begin
      if (!map_set[bidx])
        transfer(CMD_WR_MAP, 2'($urandom), 10'($urandom), 9'($urandom), bidx[13:0],
                 block_word());
      blk = map_word[bidx];
      if (blk[ID_W-1:0] != 0) begin
        midx = ((int'(blk[ID_W-1:0]) - 1) << 4)
               + (sub ^ {blk[FLIP_Y_BIT], blk[FLIP_Y_BIT], blk[FLIP_X_BIT], blk[FLIP_X_BIT]});
        if (midx < MT_DEPTH && !tile_set[midx])
          transfer(CMD_WR_TILE, 2'($urandom), 10'($urandom), 9'($urandom), midx[13:0],
                   16'($urandom));
      end
    end
    transfer(CMD_LOOKUP, lyr, sx, sy, 14'($urandom), 16'($urandom));
  endtask

  task automatic random_item();
    int          pick;
    logic [1:0]  lyr;
    logic [9:0]  sx;
    logic [8:0]  sy;
    logic [13:0] addr;
    pick = $urandom_range(99);
    lyr = ($urandom_range(99) < 88) ? ($urandom_range(1) ? LAYER_BG2 : LAYER_BG1) : 2'($urandom);
    sx = ($urandom_range(99) < 85) ? 10'(int'($urandom_range(383)) - 64) : 10'($urandom);
    sy = ($urandom_range(99) < 85) ? 9'(int'($urandom_range(319)) - 64) : 9'($urandom);
    addr = 14'($urandom);
    if (pick < 70) begin
      lookup(lyr, sx, sy);
    end else if (pick < 82) begin
      if ($urandom_range(99) < 80) addr = 14'($urandom_range(BM_DEPTH - 1));
      transfer(CMD_WR_MAP, lyr, sx, sy, addr,
               ($urandom_range(99) < 70) ? block_word() : 16'($urandom));
    end else if (pick < 94) begin
      if ($urandom_range(99) < 80) addr = 14'($urandom_range(MT_DEPTH - 1));
      transfer(CMD_WR_TILE, lyr, sx, sy, addr, 16'($urandom));
    end else begin
      transfer(CMD_NONE, lyr, sx, sy, addr, 16'($urandom));
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_registers(logic [15:0] cx, logic [15:0] cy, logic [7:0] rw,
                               logic tr, logic ld);
    cam_x = cx;
    cam_y = cy;
    room_w = rw;
    in_transition = tr;
    loaded = ld;
    cfg_we <= 1'b1;
    cfg_index <= CFG_CAMERA_X;
    cfg_data <= cx;
    @(posedge clk);
    cfg_index <= CFG_CAMERA_Y;
    cfg_data <= cy;
    @(posedge clk);
    cfg_index <= CFG_ROOM_WIDTH;
    cfg_data <= {8'($urandom), rw};
    @(posedge clk);
    cfg_index <= CFG_TRANSITION;
    cfg_data <= {15'($urandom), tr};
    @(posedge clk);
    cfg_index <= CFG_ROOM_LOADED;
    cfg_data <= {15'($urandom), ld};
    @(posedge clk);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  task automatic run_phase(int count);
    int stop;
    stop = n_items + count;
    case (n_phases % 4)
      1: idle_pct = 57;
      3: idle_pct = 33;
      default: idle_pct = 0;
    endcase
    while (n_items < stop) random_item();
    drain();
  endtask

  initial begin
    logic [7:0]  rw;
    logic [15:0] cx, cy;
    rst <= 1'b1;
    start <= 1'b0;
    command <= CMD_LOOKUP;
    layer <= LAYER_BG0;
    screen_x <= '0;
    sample_y <= '0;
    write_address <= '0;
    write_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CAMERA_X;
    cfg_data <= '0;
    cam_x = '0;
    cam_y = '0;
    room_w = '0;
    in_transition = 1'b0;
    loaded = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Settings as after reset: no room is loaded, so lookups are inactive.
    transfer(CMD_NONE, 2'b11, 10'h3FF, 9'h1FF, 14'h3FFF, 16'hFFFF);
    transfer(CMD_LOOKUP, LAYER_BG0, 10'd0, 9'd0, 14'd0, 16'd0);
    transfer(CMD_LOOKUP, LAYER_BG3, 10'd0, 9'd0, 14'd0, 16'd0);
    lookup(LAYER_BG1, 10'd0, 9'd0);
    transfer(CMD_WR_MAP, LAYER_BG0, 10'd0, 9'd0, 14'd0, 16'h4001);
    transfer(CMD_WR_MAP, LAYER_BG0, 10'd0, 9'd0, 14'd4095, 16'hFFFF);
    transfer(CMD_WR_MAP, LAYER_BG0, 10'd0, 9'd0, 14'd4096, 16'h1234);
    transfer(CMD_WR_MAP, LAYER_BG0, 10'd0, 9'd0, 14'h3FFF, 16'h0000);
    transfer(CMD_WR_TILE, LAYER_BG0, 10'd0, 9'd0, 14'd0, 16'h0000);
    transfer(CMD_WR_TILE, LAYER_BG0, 10'd0, 9'd0, 14'd8191, 16'hFFFF);
    transfer(CMD_WR_TILE, LAYER_BG0, 10'd0, 9'd0, 14'd8192, 16'hAAAA);
    transfer(CMD_WR_TILE, LAYER_BG0, 10'd0, 9'd0, 14'h3FFF, 16'h5555);
    drain();

    // Two-screen room with the camera at the left wall.
    set_registers(16'd0, 16'd0, 8'd2, 1'b0, 1'b1);
    lookup(LAYER_BG1, 10'h3C0, 9'd0);
    lookup(LAYER_BG2, 10'd0, 9'h1C0);
    lookup(LAYER_BG1, 10'd0, 9'd0);
    lookup(LAYER_BG2, 10'd319, 9'd255);
    lookup(LAYER_BG1, 10'h1FF, 9'h0FF);
    transfer(CMD_WR_MAP, LAYER_BG0, 10'd0, 9'd0, 14'd16, 16'h8002);
    lookup(LAYER_BG1, 10'd8, 9'd40);
    transfer(CMD_WR_MAP, LAYER_BG0, 10'd0, 9'd0, 14'd17, 16'hC003);
    lookup(LAYER_BG2, 10'd40, 9'd32);
    transfer(CMD_WR_MAP, LAYER_BG0, 10'd0, 9'd0, 14'd1, 16'h0000);
    lookup(LAYER_BG1, 10'd32, 9'd0);
    transfer(CMD_WR_MAP, LAYER_BG0, 10'd0, 9'd0, 14'd2, 16'h0201);
    lookup(LAYER_BG2, 10'd64, 9'd0);
    run_phase(100);

    set_registers(16'd100, 16'd40, 8'd4, 1'b0, 1'b1);
    run_phase(100);
    set_registers(16'hFFFF, 16'hFFFF, 8'd255, 1'b0, 1'b1);
    run_phase(100);
    set_registers(16'd500, 16'd1000, 8'd3, 1'b1, 1'b1);
    run_phase(40);
    set_registers(16'd300, 16'd20, 8'd1, 1'b0, 1'b1);
    run_phase(40);
    set_registers(16'd1234, 16'd5000, 8'd8, 1'b0, 1'b0);
    run_phase(40);
    set_registers(16'd21, 16'd0, 8'd255, 1'b0, 1'b1);
    run_phase(100);
    set_registers(16'd251, 16'd100, 8'd2, 1'b0, 1'b1);
    run_phase(80);
    set_registers(16'd22, 16'd10, 8'd2, 1'b0, 1'b1);
    run_phase(80);

    repeat (6) begin
      rw = ($urandom_range(99) < 70) ? 8'($urandom_range(2, 8)) : 8'($urandom);
      cx = ($urandom_range(99) < 75) ? 16'($urandom_range(0, int'(rw) * 256 + 32))
                                     : 16'($urandom);
      cy = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
      set_registers(cx, cy, rw, $urandom_range(99) < 10, $urandom_range(99) < 92);
      run_phase(100);
    end

    $display("Summary: %0d transfers under %0d register settings, %0d results checked.",
             n_items, n_phases, checked);
    $display("Summary: %0d lookups returned a merged tile entry.", replaced);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/wmf_pkg.sv
hw/rtl/widescreen_metatile_fetch_unit.sv
verif/wmf_checker.sv
verif/tb.sv
